@@ hdl/servo_dispense_sequencer_defines.svh @@
// ----------------------------------------------------------------------------
// Servo dispense sequencer: assertion macros
// Clocked on clk_i, disabled while rst_ni is low.
// ----------------------------------------------------------------------------
`ifndef SERVO_DISPENSE_SEQUENCER_DEFINES_SVH
`define SERVO_DISPENSE_SEQUENCER_DEFINES_SVH

// same-cycle implication
`define SDS_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define SDS_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ hdl/sds_pkg.sv @@
// ----------------------------------------------------------------------------
// sds_pkg
// Shared types, widths and constants of the servo dispense sequencer.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package sds_pkg;

  localparam int MODULES_DEF = 8;

  localparam int CMD_W      = 2;
  localparam int MOD_W      = 3;
  localparam int MOD_SLOTS  = 1 << MOD_W;
  localparam int IR_W       = 8;
  localparam int IN_DATA_W  = ((MOD_W + IR_W + 7) / 8) * 8;

  localparam int CH_W       = 4;
  localparam int OFF_W      = 10;
  localparam int STATUS_W   = 2;
  localparam int RES_W      = 1 + CH_W + OFF_W + 1 + STATUS_W + 1;
  localparam int OUT_DATA_W = ((RES_W + 7) / 8) * 8;

  localparam int TIME_W     = 32;
  localparam int MS_W       = 16;
  localparam int ANGLE_W    = 8;
  localparam int ATT_W      = 4;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  localparam int QUEUE_DEPTH = 2;

  localparam logic [TIME_W-1:0]  POLL_GAP_MS = TIME_W'(50);
  localparam logic [ANGLE_W-1:0] ANGLE_MAX   = ANGLE_W'(180);
  localparam logic [OFF_W-1:0]   OFF_BASE    = OFF_W'(150);
  localparam logic [OFF_W-1:0]   OFF_MAX     = OFF_W'(600);
  localparam logic [ATT_W-1:0]   ATT_CAP     = ATT_W'(15);

  // register reset values
  localparam logic                 DRIVER_RST     = 1'b1;
  localparam logic                 SENSOR_RST     = 1'b1;
  localparam logic [ANGLE_W-1:0]   HOME_ANGLE_RST = ANGLE_W'(0);
  localparam logic [ANGLE_W-1:0]   DISP_ANGLE_RST = ANGLE_W'(90);
  localparam logic [MS_W-1:0]      DISP_MS_RST    = MS_W'(1200);
  localparam logic [MS_W-1:0]      HOME_MS_RST    = MS_W'(1500);
  localparam logic [MS_W-1:0]      RETRY_MS_RST   = MS_W'(1000);
  localparam logic [ATT_W-1:0]     MAX_ATT_RST    = ATT_W'(3);

  // dispense status codes
  localparam logic [STATUS_W-1:0] ST_BUSY    = 2'd0;
  localparam logic [STATUS_W-1:0] ST_SUCCESS = 2'd1;
  localparam logic [STATUS_W-1:0] ST_EMPTY   = 2'd2;

  typedef enum logic [CMD_W-1:0] {
    CMD_TICK   = 2'd0,
    CMD_START  = 2'd1,
    CMD_TOGGLE = 2'd2,
    CMD_NOP    = 2'd3
  } cmd_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_DRIVER     = 3'd0,
    CFG_SENSOR     = 3'd1,
    CFG_HOME_ANGLE = 3'd2,
    CFG_DISP_ANGLE = 3'd3,
    CFG_DISP_MS    = 3'd4,
    CFG_HOME_MS    = 3'd5,
    CFG_RETRY_MS   = 3'd6,
    CFG_MAX_ATT    = 3'd7
  } cfg_reg_e;

  // what the back end has to do with a request
  typedef enum logic [1:0] {
    K_TICK,
    K_START,
    K_TOGGLE,
    K_NONE
  } item_kind_e;

  typedef struct packed {
    item_kind_e       kind;
    logic             in_range;
    logic [MOD_W-1:0] module_index;
    logic [IR_W-1:0]  ir_byte;
  } item_t;

  // first member sits in the top bits
  typedef struct packed {
    logic                manual_active;
    logic [STATUS_W-1:0] dispense_status;
    logic                start_accepted;
    logic [OFF_W-1:0]    pwm_off;
    logic [CH_W-1:0]     pwm_channel;
    logic                pwm_valid;
  } result_t;

  // 150 + angle*450/180 = 150 + (angle*5)/2, angle saturated at 180
  function automatic logic [OFF_W-1:0] angle_to_off(input logic [ANGLE_W-1:0] angle);
    logic [ANGLE_W-1:0] sat;
    logic [OFF_W-1:0]   times5;
    sat    = (angle > ANGLE_MAX) ? ANGLE_MAX : angle;
    times5 = (OFF_W'(sat) << 2) + OFF_W'(sat);
    return OFF_BASE + (times5 >> 1);
  endfunction

endpackage

@@ hdl/sds_front.sv @@
// ----------------------------------------------------------------------------
// sds_front
// Unpacks an incoming request and classifies it for the back end.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module sds_front #(
  parameter int MODULES = sds_pkg::MODULES_DEF
) (
  input  logic [sds_pkg::IN_DATA_W-1:0] tdata_i,  // module_index[2:0], ir_byte[10:3]
  input  logic [sds_pkg::CMD_W-1:0]     tuser_i,  // cmd[1:0]
  output sds_pkg::item_t                item_o
);
  import sds_pkg::*;

  logic [MOD_W-1:0] mod;
  logic             in_range;

  assign mod      = tdata_i[MOD_W-1:0];
  assign in_range = (32'(mod) < MODULES);

  always_comb begin
    item_o.module_index = mod;
    item_o.ir_byte      = tdata_i[MOD_W +: IR_W];
    item_o.in_range     = in_range;
    unique case (cmd_e'(tuser_i))
      CMD_TICK:   item_o.kind = K_TICK;
      CMD_START:  item_o.kind = K_START;
      // a toggle of a slot that does not exist has no effect
      CMD_TOGGLE: item_o.kind = in_range ? K_TOGGLE : K_NONE;
      CMD_NOP:    item_o.kind = K_NONE;
    endcase
  end

endmodule

@@ hdl/sds_fifo.sv @@
// ----------------------------------------------------------------------------
// sds_fifo
// Short queue of classified requests between front and back end.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module sds_fifo (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  sds_pkg::item_t item_i,
  output logic           ready_o,
  input  logic           pop_i,
  output logic           valid_o,
  output sds_pkg::item_t item_o
);
  import sds_pkg::*;

  localparam int PTR_W = $clog2(QUEUE_DEPTH);

  item_t            mem_q [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [PTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [PTR_W:0]   count_q, count_d;
  logic             do_push, do_pop;

  assign ready_o = (count_q != (PTR_W + 1)'(QUEUE_DEPTH));
  assign valid_o = (count_q != '0);
  assign item_o  = mem_q[rd_ptr_q];

  assign do_push = push_i && ready_o;
  assign do_pop  = pop_i && valid_o;

  always_comb begin
    wr_ptr_d = do_push ? wr_ptr_q + 1'b1 : wr_ptr_q;
    rd_ptr_d = do_pop  ? rd_ptr_q + 1'b1 : rd_ptr_q;
    count_d  = count_q + (PTR_W + 1)'(do_push) - (PTR_W + 1)'(do_pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= item_i;
    end
  end

endmodule

@@ hdl/sds_back.sv @@
// ----------------------------------------------------------------------------
// sds_back
// Dispense sequencer: timekeeping, phase control, sensor polling, manual
// flags, configuration registers and the registered result stage.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module sds_back (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [sds_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input  logic [sds_pkg::CFG_DATA_W-1:0]  cfg_data_i,
  input  logic                            item_valid_i,
  input  sds_pkg::item_t                  item_i,
  output logic                            pop_o,
  output logic                            res_valid_o,
  input  logic                            res_ready_i,
  output sds_pkg::result_t                res_o
);
  import sds_pkg::*;

  localparam logic [1:0] PH_IDLE = 2'd0;
  localparam logic [1:0] PH_DISP = 2'd1;
  localparam logic [1:0] PH_HOME = 2'd2;
  localparam logic [1:0] PH_WAIT = 2'd3;

  // configuration
  logic               driver_q, sensor_q;
  logic [ANGLE_W-1:0] home_angle_q, disp_angle_q;
  logic [MS_W-1:0]    disp_ms_q, home_ms_q, retry_ms_q;
  logic [ATT_W-1:0]   max_att_q;

  // sequencer state
  logic [TIME_W-1:0]    time_q, time_d;
  logic [TIME_W-1:0]    phase_start_q, phase_start_d;
  logic [TIME_W-1:0]    last_poll_q, last_poll_d;
  logic [1:0]           phase_q, phase_d;
  logic [MOD_W-1:0]     task_mod_q, task_mod_d;
  logic                 task_in_range_q, task_in_range_d;
  logic [ATT_W-1:0]     attempts_q, attempts_d;
  logic                 pill_q, pill_d;
  logic [STATUS_W-1:0]  final_q, final_d;
  logic [MOD_SLOTS-1:0] manual_q, manual_d;

  logic                 res_valid_q;
  result_t              res_q, res_d;

  logic [TIME_W-1:0]  now, el_phase, el_poll;
  logic [ATT_W-1:0]   att_inc;
  logic               poll_hit, pill_new;
  logic [OFF_W-1:0]   home_off, disp_off;
  item_kind_e         kind;

  assign pop_o       = item_valid_i && (!res_valid_q || res_ready_i);
  assign res_valid_o = res_valid_q;
  assign res_o       = res_q;

  // empty queue slot decodes as no operation
  assign kind = item_valid_i ? item_i.kind : K_NONE;

  assign home_off = angle_to_off(home_angle_q);
  assign disp_off = angle_to_off(disp_angle_q);

  assign now      = time_q + TIME_W'(1);
  assign el_phase = now - phase_start_q;
  assign el_poll  = now - last_poll_q;
  assign att_inc  = (attempts_q < ATT_CAP) ? attempts_q + 1'b1 : attempts_q;

  // channel is always below 8 here, so only the bit level matters
  assign poll_hit = sensor_q && !pill_q && (phase_q == PH_DISP || phase_q == PH_HOME)
                    && (el_poll > POLL_GAP_MS);
  assign pill_new = pill_q || (poll_hit && !item_i.ir_byte[task_mod_q]);

  always_comb begin
    time_d          = time_q;
    phase_start_d   = phase_start_q;
    last_poll_d     = last_poll_q;
    phase_d         = phase_q;
    task_mod_d      = task_mod_q;
    task_in_range_d = task_in_range_q;
    attempts_d      = attempts_q;
    pill_d          = pill_q;
    final_d         = final_q;
    manual_d        = manual_q;
    res_d           = '0;

    unique case (kind)
      K_TICK: begin
        time_d = now;
        if (driver_q && phase_q != PH_IDLE) begin
          if (poll_hit) begin
            last_poll_d = now;
          end
          pill_d = pill_new;
          unique case (phase_q)
            PH_DISP: begin
              if (el_phase >= TIME_W'(disp_ms_q)) begin
                res_d.pwm_valid   = 1'b1;
                res_d.pwm_channel = CH_W'(task_mod_q);
                res_d.pwm_off     = home_off;
                phase_d           = PH_HOME;
                phase_start_d     = now;
              end
            end
            PH_HOME: begin
              if (el_phase >= TIME_W'(home_ms_q)) begin
                // release the servo, then judge the attempt
                res_d.pwm_valid   = 1'b1;
                res_d.pwm_channel = CH_W'(task_mod_q);
                res_d.pwm_off     = '0;
                if (pill_new || !sensor_q) begin
                  final_d = ST_SUCCESS;
                  phase_d = PH_IDLE;
                  if (task_in_range_q) begin
                    manual_d[task_mod_q] = 1'b0;
                  end
                end else begin
                  attempts_d = att_inc;
                  if (att_inc >= max_att_q) begin
                    final_d = ST_EMPTY;
                    phase_d = PH_IDLE;
                    if (task_in_range_q) begin
                      manual_d[task_mod_q] = 1'b0;
                    end
                  end else begin
                    phase_d       = PH_WAIT;
                    phase_start_d = now;
                  end
                end
              end
            end
            PH_WAIT: begin
              if (el_phase >= TIME_W'(retry_ms_q)) begin
                res_d.pwm_valid   = 1'b1;
                res_d.pwm_channel = CH_W'(task_mod_q);
                res_d.pwm_off     = disp_off;
                phase_d           = PH_DISP;
                phase_start_d     = now;
              end
            end
            PH_IDLE: begin
            end
          endcase
        end
      end
      K_START: begin
        if (driver_q && phase_q == PH_IDLE) begin
          res_d.pwm_valid      = 1'b1;
          res_d.pwm_channel    = CH_W'(item_i.module_index);
          res_d.pwm_off        = disp_off;
          res_d.start_accepted = 1'b1;
          phase_d              = PH_DISP;
          phase_start_d        = time_q;
          task_mod_d           = item_i.module_index;
          task_in_range_d      = item_i.in_range;
          attempts_d           = '0;
          pill_d               = 1'b0;
          final_d              = ST_BUSY;
        end
      end
      K_TOGGLE: begin
        if (driver_q) begin
          manual_d[item_i.module_index] = !manual_q[item_i.module_index];
          res_d.pwm_valid   = 1'b1;
          res_d.pwm_channel = CH_W'(item_i.module_index);
          res_d.pwm_off     = manual_q[item_i.module_index] ? home_off : disp_off;
        end
      end
      K_NONE: begin
      end
    endcase

    res_d.dispense_status = (phase_d != PH_IDLE) ? ST_BUSY : final_d;
    res_d.manual_active   = item_i.in_range && manual_d[item_i.module_index];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      driver_q     <= DRIVER_RST;
      sensor_q     <= SENSOR_RST;
      home_angle_q <= HOME_ANGLE_RST;
      disp_angle_q <= DISP_ANGLE_RST;
      disp_ms_q    <= DISP_MS_RST;
      home_ms_q    <= HOME_MS_RST;
      retry_ms_q   <= RETRY_MS_RST;
      max_att_q    <= MAX_ATT_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_reg_e'(cfg_idx_i))
        CFG_DRIVER:     driver_q     <= cfg_data_i[0];
        CFG_SENSOR:     sensor_q     <= cfg_data_i[0];
        CFG_HOME_ANGLE: home_angle_q <= cfg_data_i[ANGLE_W-1:0];
        CFG_DISP_ANGLE: disp_angle_q <= cfg_data_i[ANGLE_W-1:0];
        CFG_DISP_MS:    disp_ms_q    <= cfg_data_i[MS_W-1:0];
        CFG_HOME_MS:    home_ms_q    <= cfg_data_i[MS_W-1:0];
        CFG_RETRY_MS:   retry_ms_q   <= cfg_data_i[MS_W-1:0];
        CFG_MAX_ATT:    max_att_q    <= cfg_data_i[ATT_W-1:0];
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      time_q          <= '0;
      phase_start_q   <= '0;
      last_poll_q     <= '0;
      phase_q         <= PH_IDLE;
      task_mod_q      <= '0;
      task_in_range_q <= 1'b0;
      attempts_q      <= '0;
      pill_q          <= 1'b0;
      final_q         <= ST_BUSY;
      manual_q        <= '0;
      res_valid_q     <= 1'b0;
    end else begin
      if (pop_o) begin
        time_q          <= time_d;
        phase_start_q   <= phase_start_d;
        last_poll_q     <= last_poll_d;
        phase_q         <= phase_d;
        task_mod_q      <= task_mod_d;
        task_in_range_q <= task_in_range_d;
        attempts_q      <= attempts_d;
        pill_q          <= pill_d;
        final_q         <= final_d;
        manual_q        <= manual_d;
        res_valid_q     <= 1'b1;
      end else if (res_ready_i) begin
        res_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      res_q <= res_d;
    end
  end

endmodule

@@ hdl/servo_dispense_sequencer.sv @@
// ----------------------------------------------------------------------------
// servo_dispense_sequencer
// Runs the swing / return / retry cycle of one dispenser module's servo,
// polls the pill sensor and reports PWM writes and dispense status.
// ----------------------------------------------------------------------------
//  channel   | dir | handshake                     | payload
//  s_axis    | in  | s_axis_tvalid / s_axis_tready | tuser cmd, tdata module, ir byte
//  m_axis    | out | m_axis_tvalid / m_axis_tready | tdata pwm write, status, manual
//  cfg       | in  | cfg_we_i (no back-pressure)   | cfg_idx_i, cfg_data_i
//
// One request per clock while s_axis_tready is high. The back end executes each
// queued request and registers its result once the result register is free.
// A two-entry request queue sits between classifier and sequencer; s_axis_tready
// drops only when it is full while the result register is held by m_axis_tready.
// Reset clears the control state and loads the register defaults; no clearing pass.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module servo_dispense_sequencer #(
  parameter int MODULES = sds_pkg::MODULES_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  // module_index[2:0], ir_byte[10:3], zero fill above
  input  logic [sds_pkg::IN_DATA_W-1:0]   s_axis_tdata,
  // cmd[1:0]
  input  logic [sds_pkg::CMD_W-1:0]       s_axis_tuser,
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  // pwm_valid[0], pwm_channel[4:1], pwm_off[14:5], start_accepted[15],
  // dispense_status[17:16], manual_active[18], zero fill above
  output logic [sds_pkg::OUT_DATA_W-1:0]  m_axis_tdata,
  input  logic                            cfg_we_i,
  input  logic [sds_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input  logic [sds_pkg::CFG_DATA_W-1:0]  cfg_data_i
);
  import sds_pkg::*;

  item_t   front_item, queue_item;
  logic    queue_valid, queue_pop;
  result_t res;

  sds_front #(
    .MODULES (MODULES)
  ) u_front (
    .tdata_i (s_axis_tdata),
    .tuser_i (s_axis_tuser),
    .item_o  (front_item)
  );

  sds_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (s_axis_tvalid),
    .item_i  (front_item),
    .ready_o (s_axis_tready),
    .pop_i   (queue_pop),
    .valid_o (queue_valid),
    .item_o  (queue_item)
  );

  sds_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_data_i   (cfg_data_i),
    .item_valid_i (queue_valid),
    .item_i       (queue_item),
    .pop_o        (queue_pop),
    .res_valid_o  (m_axis_tvalid),
    .res_ready_i  (m_axis_tready),
    .res_o        (res)
  );

  assign m_axis_tdata = OUT_DATA_W'(res);

endmodule

@@ hdl/sds_chk.sv @@
// ----------------------------------------------------------------------------
// sds_chk
// Port-level checks on the result stream of the dispense sequencer.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "servo_dispense_sequencer_defines.svh"

module sds_chk (
  input logic                            clk_i,
  input logic                            rst_ni,
  input logic                            m_axis_tvalid,
  input logic                            m_axis_tready,
  input logic [sds_pkg::OUT_DATA_W-1:0]  m_axis_tdata
);
  import sds_pkg::*;

  result_t res;

  assign res = result_t'(m_axis_tdata[RES_W-1:0]);

  `SDS_ASSERT_IMP(a_no_write_zero, m_axis_tvalid && !res.pwm_valid, res.pwm_channel == '0 && res.pwm_off == '0, "pwm fields set without a write")
  `SDS_ASSERT_IMP(a_start_busy, m_axis_tvalid && res.start_accepted, res.pwm_valid && res.dispense_status == ST_BUSY && res.pwm_off != '0, "accepted start without busy swing")
  `SDS_ASSERT_IMP(a_off_range, m_axis_tvalid && res.pwm_off != '0, res.pwm_off >= OFF_BASE && res.pwm_off <= OFF_MAX, "pwm off count out of range")
  `SDS_ASSERT_NXT(a_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata), "result changed while stalled")

endmodule

bind servo_dispense_sequencer sds_chk u_sds_chk (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);

@@ test/tb_servo_dispense_sequencer.sv @@
// ----------------------------------------------------------------------------
// tb_servo_dispense_sequencer
// Self-checking bench for the servo dispense sequencer. A directed table
// (reset values, angle saturation, refusals, empty and success endings) is
// followed by random phases of ticks, starts and toggles under changing
// register settings; results are checked against the table or a predictor.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_servo_dispense_sequencer;
  import sds_pkg::*;

  localparam int LIMIT_CYCLES = 400000;

  typedef enum logic [1:0] {
    SEQ_IDLE,
    SEQ_SWING,
    SEQ_HOME,
    SEQ_RETRY
  } seq_phase_e;

  typedef struct packed {
    logic                  is_cfg;
    cfg_reg_e              cfg_idx;
    logic [CFG_DATA_W-1:0] cfg_val;
    cmd_e                  cmd;
    logic [MOD_W-1:0]      module_idx;
    logic [IR_W-1:0]       ir;
    logic                  typed;
    result_t               want;
  } stim_row_t;

  logic                  clk_i;
  logic                  rst_ni;
  logic                  s_axis_tvalid;
  logic                  s_axis_tready;
  logic [IN_DATA_W-1:0]  s_axis_tdata;
  logic [CMD_W-1:0]      s_axis_tuser;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready;
  logic [OUT_DATA_W-1:0] m_axis_tdata;
  logic                  cfg_we_i;
  logic [CFG_IDX_W-1:0]  cfg_idx_i;
  logic [CFG_DATA_W-1:0] cfg_data_i;

  servo_dispense_sequencer dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i)
  );

  // register copies
  logic               cf_driver, cf_sensor;
  logic [ANGLE_W-1:0] cf_home_angle, cf_disp_angle;
  logic [MS_W-1:0]    cf_disp_ms, cf_home_ms, cf_retry_ms;
  logic [ATT_W-1:0]   cf_max_att;

  // sequencer state as predicted
  logic [TIME_W-1:0]      seq_time, seq_phase_start, seq_last_poll;
  logic                   seq_active, seq_pill;
  seq_phase_e             seq_phase;
  logic [MOD_W-1:0]       seq_module;
  logic [ATT_W-1:0]       seq_attempts;
  logic [STATUS_W-1:0]    seq_status;
  logic [MODULES_DEF-1:0] seq_manual;

  result_t   outcome_q[$];
  stim_row_t plan[$];
  result_t   got_res, want_res;

  int fail_count;
  int cycle_count;
  int rx_cycle, stall_left;
  int burst_left, gap_max;
  int ph, k, n_items, ir_mode, pick;
  cmd_e               r_cmd;
  logic [IR_W-1:0]    r_ir;
  logic               s_drv, s_sns;
  logic [ANGLE_W-1:0] s_ha, s_da;
  logic [MS_W-1:0]    s_dms, s_hms, s_rms;
  logic [ATT_W-1:0]   s_ma;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // --------------------------------------------------------------------------
  // Predictor
  // --------------------------------------------------------------------------
  function automatic logic [OFF_W-1:0] off_for_angle(logic [ANGLE_W-1:0] a);
    int s;
    s = (a > 8'd180) ? 180 : int'(a);
    return OFF_W'(150 + s * 450 / 180);
  endfunction

  function automatic void end_cycle(logic [STATUS_W-1:0] st);
    seq_status = st;
    seq_manual[seq_module] = 1'b0;
    seq_active = 1'b0;
    seq_phase = SEQ_IDLE;
  endfunction

  function automatic result_t compute_outcome(cmd_e c, logic [MOD_W-1:0] m,
                                              logic [IR_W-1:0] ir);
    result_t           r;
    logic [TIME_W-1:0] now;
    logic              wr;
    logic [MOD_W-1:0]  ch;
    logic [OFF_W-1:0]  off;
    r   = '0;
    wr  = 1'b0;
    ch  = '0;
    off = '0;
    case (c)
      CMD_TICK: begin
        seq_time = seq_time + 1;
        now = seq_time;
        if (cf_driver && seq_active) begin
          // sensor sampled at most once per 51 ms while swinging or returning
          if (cf_sensor && !seq_pill && (seq_phase == SEQ_SWING || seq_phase == SEQ_HOME)
              && (now - seq_last_poll) > 32'd50) begin
            seq_last_poll = now;
            if (!ir[seq_module]) seq_pill = 1'b1;
          end
          case (seq_phase)
            SEQ_SWING: begin
              if (now - seq_phase_start >= TIME_W'(cf_disp_ms)) begin
                wr = 1'b1;
                ch = seq_module;
                off = off_for_angle(cf_home_angle);
                seq_phase = SEQ_HOME;
                seq_phase_start = now;
              end
            end
            SEQ_HOME: begin
              if (now - seq_phase_start >= TIME_W'(cf_home_ms)) begin
                wr = 1'b1;
                ch = seq_module;
                off = '0;
                if (seq_pill || !cf_sensor) begin
                  end_cycle(ST_SUCCESS);
                end else begin
                  if (seq_attempts != 4'd15) seq_attempts = seq_attempts + 1'b1;
                  if (seq_attempts >= cf_max_att) begin
                    end_cycle(ST_EMPTY);
                  end else begin
                    seq_phase = SEQ_RETRY;
                    seq_phase_start = now;
                  end
                end
              end
            end
            SEQ_RETRY: begin
              if (now - seq_phase_start >= TIME_W'(cf_retry_ms)) begin
                wr = 1'b1;
                ch = seq_module;
                off = off_for_angle(cf_disp_angle);
                seq_phase = SEQ_SWING;
                seq_phase_start = now;
              end
            end
            default: ;
          endcase
        end
      end
      CMD_START: begin
        if (cf_driver && !seq_active) begin
          wr = 1'b1;
          ch = m;
          off = off_for_angle(cf_disp_angle);
          seq_active = 1'b1;
          seq_phase = SEQ_SWING;
          seq_phase_start = seq_time;
          seq_module = m;
          seq_attempts = '0;
          seq_pill = 1'b0;
          seq_status = ST_BUSY;
          r.start_accepted = 1'b1;
        end
      end
      CMD_TOGGLE: begin
        if (cf_driver) begin
          seq_manual[m] = !seq_manual[m];
          wr = 1'b1;
          ch = m;
          off = off_for_angle(seq_manual[m] ? cf_disp_angle : cf_home_angle);
        end
      end
      default: ;
    endcase
    r.pwm_valid       = wr;
    r.pwm_channel     = wr ? CH_W'(ch) : '0;
    r.pwm_off         = wr ? off : '0;
    r.dispense_status = seq_active ? ST_BUSY : seq_status;
    r.manual_active   = seq_manual[m];
    return r;
  endfunction

  // --------------------------------------------------------------------------
  // Directed table helpers
  // --------------------------------------------------------------------------
  function automatic result_t outcome(logic v, logic [CH_W-1:0] ch, logic [OFF_W-1:0] off,
                                      logic acc, logic [STATUS_W-1:0] st, logic man);
    result_t r;
    r.pwm_valid       = v;
    r.pwm_channel     = ch;
    r.pwm_off         = off;
    r.start_accepted  = acc;
    r.dispense_status = st;
    r.manual_active   = man;
    return r;
  endfunction

  function automatic void add_req(cmd_e c, logic [MOD_W-1:0] m, logic [IR_W-1:0] ir);
    stim_row_t row;
    row = '0;
    row.cmd = c;
    row.module_idx = m;
    row.ir = ir;
    plan.push_back(row);
  endfunction

  function automatic void add_checked(cmd_e c, logic [MOD_W-1:0] m, logic [IR_W-1:0] ir,
                                      result_t want);
    stim_row_t row;
    row = '0;
    row.cmd = c;
    row.module_idx = m;
    row.ir = ir;
    row.typed = 1'b1;
    row.want = want;
    plan.push_back(row);
  endfunction

  function automatic void add_cfg(cfg_reg_e idx, logic [CFG_DATA_W-1:0] v);
    stim_row_t row;
    row = '0;
    row.is_cfg = 1'b1;
    row.cfg_idx = idx;
    row.cfg_val = v;
    plan.push_back(row);
  endfunction

  // --------------------------------------------------------------------------
  // Stimulus tasks
  // --------------------------------------------------------------------------
  task automatic send_item(cmd_e c, logic [MOD_W-1:0] m, logic [IR_W-1:0] ir,
                           logic typed, result_t want);
    result_t predicted;
    int      gap;
    if (gap_max > 0 && burst_left == 0) begin
      gap = $urandom_range(1, gap_max);
      repeat (gap) begin
        @(negedge clk_i);
        s_axis_tvalid <= 1'b0;
      end
      burst_left = $urandom_range(1, 20);
    end
    @(negedge clk_i);
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {{(IN_DATA_W - MOD_W - IR_W){1'b0}}, ir, m};
    s_axis_tuser  <= c;
    do @(posedge clk_i); while (!s_axis_tready);
    predicted = compute_outcome(c, m, ir);
    outcome_q.push_back(typed ? want : predicted);
    if (burst_left > 0) burst_left--;
  endtask

  // hold the sender until every outstanding result has come back
  task automatic settle_outstanding();
    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;
    while (outcome_q.size() != 0) @(posedge clk_i);
    repeat (2) @(posedge clk_i);
  endtask

  task automatic write_reg(cfg_reg_e idx, logic [CFG_DATA_W-1:0] v);
    settle_outstanding();
    @(negedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= v;
    case (idx)
      CFG_DRIVER:     cf_driver     = v[0];
      CFG_SENSOR:     cf_sensor     = v[0];
      CFG_HOME_ANGLE: cf_home_angle = v[ANGLE_W-1:0];
      CFG_DISP_ANGLE: cf_disp_angle = v[ANGLE_W-1:0];
      CFG_DISP_MS:    cf_disp_ms    = v[MS_W-1:0];
      CFG_HOME_MS:    cf_home_ms    = v[MS_W-1:0];
      CFG_RETRY_MS:   cf_retry_ms   = v[MS_W-1:0];
      default:        cf_max_att    = v[ATT_W-1:0];
    endcase
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  // --------------------------------------------------------------------------
  // Result checking
  // --------------------------------------------------------------------------
  function automatic void check_field(string name, int unsigned exp_v, int unsigned got_v);
    if (exp_v != got_v) begin
      $error("%s: expected %0d, got %0d", name, exp_v, got_v);
      fail_count++;
    end
  endfunction

  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got_res = m_axis_tdata[RES_W-1:0];
      if (outcome_q.size() == 0) begin
        $error("result with no request outstanding: %h", got_res);
        fail_count++;
      end else begin
        want_res = outcome_q.pop_front();
        check_field("pwm_valid", want_res.pwm_valid, got_res.pwm_valid);
        check_field("pwm_channel", want_res.pwm_channel, got_res.pwm_channel);
        check_field("pwm_off", want_res.pwm_off, got_res.pwm_off);
        check_field("start_accepted", want_res.start_accepted, got_res.start_accepted);
        check_field("dispense_status", want_res.dispense_status, got_res.dispense_status);
        check_field("manual_active", want_res.manual_active, got_res.manual_active);
      end
    end
  end

  // receiver: free-running, random, then long stall bursts
  always @(negedge clk_i) begin
    rx_cycle++;
    if (stall_left > 0) begin
      stall_left--;
      m_axis_tready <= 1'b0;
    end else begin
      case ((rx_cycle / 250) % 3)
        0: m_axis_tready <= 1'b1;
        1: m_axis_tready <= ($urandom_range(0, 99) < 60);
        default: begin
          if ($urandom_range(0, 9) == 0) begin
            stall_left = $urandom_range(1, 11);
            m_axis_tready <= 1'b0;
          end else begin
            m_axis_tready <= 1'b1;
          end
        end
      endcase
    end
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > LIMIT_CYCLES) begin
      $display("FAIL servo_dispense_sequencer");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Main sequence
  // --------------------------------------------------------------------------
  initial begin
    rst_ni        = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = CMD_TICK;
    m_axis_tready = 1'b0;
    cfg_we_i      = 1'b0;
    cfg_idx_i     = CFG_DRIVER;
    cfg_data_i    = '0;
    fail_count    = 0;
    cycle_count   = 0;
    rx_cycle      = 0;
    stall_left    = 0;
    burst_left    = 0;
    gap_max       = 3;

    cf_driver     = DRIVER_RST;
    cf_sensor     = SENSOR_RST;
    cf_home_angle = HOME_ANGLE_RST;
    cf_disp_angle = DISP_ANGLE_RST;
    cf_disp_ms    = DISP_MS_RST;
    cf_home_ms    = HOME_MS_RST;
    cf_retry_ms   = RETRY_MS_RST;
    cf_max_att    = MAX_ATT_RST;
    seq_time        = '0;
    seq_phase_start = '0;
    seq_last_poll   = '0;
    seq_active      = 1'b0;
    seq_pill        = 1'b0;
    seq_phase       = SEQ_IDLE;
    seq_module      = '0;
    seq_attempts    = '0;
    seq_status      = ST_BUSY;
    seq_manual      = '0;

    // directed table: reset defaults first
    add_checked(CMD_TICK, 3'd0, 8'hFF, outcome(0, 0, 0, 0, ST_BUSY, 0));
    add_checked(CMD_TOGGLE, 3'd7, 8'h00, outcome(1, 7, 375, 0, ST_BUSY, 1));
    add_checked(CMD_TOGGLE, 3'd7, 8'hFF, outcome(1, 7, 150, 0, ST_BUSY, 0));
    add_checked(CMD_NOP, 3'd7, 8'h55, outcome(0, 0, 0, 0, ST_BUSY, 0));
    // saturated angles, zero swing and retry times, two attempts
    add_cfg(CFG_HOME_ANGLE, 16'd255);
    add_cfg(CFG_DISP_ANGLE, 16'd180);
    add_cfg(CFG_DISP_MS, 16'd0);
    add_cfg(CFG_HOME_MS, 16'd1);
    add_cfg(CFG_RETRY_MS, 16'd0);
    add_cfg(CFG_MAX_ATT, 16'd2);
    add_checked(CMD_TOGGLE, 3'd3, 8'hAA, outcome(1, 3, 600, 0, ST_BUSY, 1));
    add_checked(CMD_START, 3'd3, 8'h00, outcome(1, 3, 600, 1, ST_BUSY, 1));
    add_checked(CMD_START, 3'd5, 8'h00, outcome(0, 0, 0, 0, ST_BUSY, 0));
    repeat (4) add_req(CMD_TICK, 3'd3, 8'hFF);
    add_checked(CMD_TICK, 3'd3, 8'hFF, outcome(1, 3, 0, 0, ST_EMPTY, 0));
    add_req(CMD_TICK, 3'd0, 8'h00);
    // no sensor: every cycle succeeds
    add_cfg(CFG_SENSOR, 16'd0);
    add_checked(CMD_START, 3'd2, 8'h00, outcome(1, 2, 600, 1, ST_BUSY, 0));
    add_req(CMD_TICK, 3'd2, 8'h00);
    add_checked(CMD_TICK, 3'd2, 8'h00, outcome(1, 2, 0, 0, ST_SUCCESS, 0));
    // no driver: commands ignored
    add_cfg(CFG_DRIVER, 16'd0);
    add_cfg(CFG_SENSOR, 16'd1);
    add_cfg(CFG_MAX_ATT, 16'd0);
    add_checked(CMD_START, 3'd1, 8'hFF, outcome(0, 0, 0, 0, ST_SUCCESS, 0));
    add_req(CMD_TOGGLE, 3'd1, 8'hFF);
    add_req(CMD_TICK, 3'd1, 8'hFF);
    add_req(CMD_NOP, 3'd4, 8'h00);
    add_cfg(CFG_DRIVER, 16'd1);
    add_req(CMD_START, 3'd6, 8'h00);
    add_req(CMD_TICK, 3'd6, 8'hFF);
    add_req(CMD_TICK, 3'd6, 8'hFF);
    add_req(CMD_TOGGLE, 3'd0, 8'h00);

    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    foreach (plan[i]) begin
      if (plan[i].is_cfg) begin
        write_reg(plan[i].cfg_idx, plan[i].cfg_val);
      end else begin
        send_item(plan[i].cmd, plan[i].module_idx, plan[i].ir, plan[i].typed,
                  plan[i].want);
      end
    end

    // random phases, each under its own register settings
    for (ph = 0; ph < 12; ph++) begin
      ir_mode = $urandom_range(0, 2);
      if (ph == 0) begin
        s_drv = 1; s_sns = 1; s_ha = 8'd180; s_da = 8'd0;
        s_dms = 16'hFFFF; s_hms = 16'hFFFF; s_rms = 16'hFFFF; s_ma = 4'd15;
      end else if (ph == 1) begin
        // instant phases, no pill: runs all the way to the attempt limit
        s_drv = 1; s_sns = 1; s_ha = 8'd0; s_da = 8'd180;
        s_dms = '0; s_hms = '0; s_rms = '0; s_ma = 4'd15;
        ir_mode = 1;
      end else begin
        s_drv = (ph != 2);
        s_sns = (ph != 3);
        s_ha  = ($urandom_range(0, 4) == 0) ? 8'($urandom_range(181, 255))
                                            : 8'($urandom_range(0, 180));
        s_da  = ($urandom_range(0, 4) == 0) ? 8'($urandom_range(181, 255))
                                            : 8'($urandom_range(0, 180));
        s_dms = 16'($urandom_range(0, 40));
        s_hms = 16'($urandom_range(0, 90));
        s_rms = 16'($urandom_range(0, 30));
        s_ma  = 4'($urandom_range(1, 5));
      end
      write_reg(CFG_DRIVER, 16'(s_drv));
      write_reg(CFG_SENSOR, 16'(s_sns));
      write_reg(CFG_HOME_ANGLE, 16'(s_ha));
      write_reg(CFG_DISP_ANGLE, 16'(s_da));
      write_reg(CFG_DISP_MS, s_dms);
      write_reg(CFG_HOME_MS, s_hms);
      write_reg(CFG_RETRY_MS, s_rms);
      write_reg(CFG_MAX_ATT, 16'(s_ma));

      gap_max = (ph % 3 == 0) ? 0 : $urandom_range(2, 6);
      burst_left = 0;
      n_items = (ph == 0) ? 40 : 100;
      for (k = 0; k < n_items; k++) begin
        if (ph % 4 == 2 && k == n_items / 2) settle_outstanding();
        pick = $urandom_range(0, 99);
        if (pick < 78)      r_cmd = CMD_TICK;
        else if (pick < 88) r_cmd = CMD_START;
        else if (pick < 95) r_cmd = CMD_TOGGLE;
        else                r_cmd = CMD_NOP;
        case (ir_mode)
          0: r_ir = 8'($urandom_range(0, 255));
          1: r_ir = 8'hFF;
          default: r_ir = ($urandom_range(0, 9) == 0) ? 8'($urandom_range(0, 255)) : 8'hFF;
        endcase
        send_item(r_cmd, 3'($urandom_range(0, 7)), r_ir, 1'b0, '0);
      end
    end

    settle_outstanding();
    repeat (4) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("PASS servo_dispense_sequencer");
    end else begin
      $display("FAIL servo_dispense_sequencer");
    end
    $finish;
  end

endmodule
